@@ rtl/lpht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SlotCount     = 26;
  localparam int SlotWidth     = $clog2(SlotCount);
  localparam int LetterWidth   = 5;
  localparam int LetterFields  = 10;
  localparam int WordWidth     = LetterWidth * LetterFields;
  localparam int PayloadWidth  = 8;
  localparam int MaxLetters    = 10;
  localparam int AlphabetSize  = 26;
  localparam int EntryWidth    = WordWidth + PayloadWidth;

  localparam logic [SlotWidth-1:0] LastSlot = SlotWidth'(SlotCount - 1);

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncDelete = 2'd1,
    FuncRead   = 2'd2,
    FuncNop    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    SlotEmpty = 2'd0,
    SlotTomb  = 2'd1,
    SlotUsed  = 2'd2
  } slot_state_e;

  // result of the key check
  typedef struct packed {
    logic                 ok;
    logic [SlotWidth-1:0] home;
  } key_info_t;

endpackage

@@ rtl/lpht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lpht_key_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_key_check
// Validates a packed key and derives its home slot from the last letter.
// ----------------------------------------------------------------------------
module lpht_key_check (
  input  logic [lpht_pkg::WordWidth-1:0] word_i,
  input  logic                           too_long_i,
  output lpht_pkg::key_info_t            info_o
);
  import lpht_pkg::*;

  always_comb begin
    logic                   ended;
    logic                   bad;
    logic                   over;
    logic [LetterWidth-1:0] c;
    logic [LetterWidth-1:0] last;
    ended = 1'b0;
    bad   = 1'b0;
    over  = 1'b0;
    last  = '0;
    for (int i = 0; i < LetterFields; i++) begin
      c = word_i[i*LetterWidth +: LetterWidth];
      if (c == '0) begin
        ended = 1'b1;
      end else begin
        if (ended || (c > LetterWidth'(AlphabetSize))) begin
          bad = 1'b1;
        end
        if (i >= MaxLetters) begin
          over = 1'b1;
        end
        last = c;
      end
    end
    info_o.ok   = !too_long_i && !bad && !over && (word_i != '0);
    // letter codes start at 1 for a, which lands on slot 0
    info_o.home = SlotWidth'(last - LetterWidth'(1));
  end

endmodule

@@ rtl/linear_probe_hash_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Flow, start to done strobe: no-op or a refused key ends in the check state,
//   a slot read passes the read-out state, insert or delete the probe loop.
// Insert/delete time is set by the probe loop: one slot per cycle through the
//   registered key RAM port and one key compare, up to all 26 slots.
// One item at a time; the next start is taken in the cycle done is high.
// Reset empties every slot at once (status flops); no clearing pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [lpht_pkg::WordWidth-1:0]    word_i,
  input  logic                              word_too_long_i,
  input  logic [lpht_pkg::PayloadWidth-1:0] payload_i,
  input  logic [4:0]                        slot_select_i,
  output logic                              done_o,
  output logic [4:0]                        slot_touched_o,
  output logic                              applied_o,
  output logic [1:0]                        slot_state_o,
  output logic [lpht_pkg::WordWidth-1:0]    stored_word_o,
  output logic [lpht_pkg::PayloadWidth-1:0] stored_payload_o,
  output logic                              rejected_o
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StProbe,
    StReadOut
  } state_e;

  state_e                  state_q;
  func_e                   func_q;
  logic [WordWidth-1:0]    word_q;
  logic                    too_long_q;
  logic [PayloadWidth-1:0] payload_q;
  logic [SlotWidth-1:0]    sel_q;

  slot_state_e             status_q [SlotCount];
  logic [SlotWidth-1:0]    idx_q;
  logic [SlotWidth-1:0]    cnt_q;
  logic [SlotWidth-1:0]    tomb_q;
  logic                    tomb_vld_q;

  logic                    done_q;
  logic [SlotWidth-1:0]    slot_touched_q;
  logic                    applied_q;
  slot_state_e             slot_state_q;
  logic [WordWidth-1:0]    stored_word_q;
  logic [PayloadWidth-1:0] stored_payload_q;
  logic                    rejected_q;

  key_info_t               key;
  logic [SlotWidth-1:0]    sel_sat;
  logic [SlotWidth-1:0]    idx_next;
  slot_state_e             cur_status;
  logic [EntryWidth-1:0]   rdata;
  logic                    cur_hit;
  logic                    cur_empty;
  logic                    cur_tomb;
  logic                    probe_last;
  logic                    probe_stop;
  logic                    tomb_now_vld;
  logic [SlotWidth-1:0]    tomb_now;
  logic                    ins_do;
  logic [SlotWidth-1:0]    ins_at;
  logic                    ram_we;
  logic [SlotWidth-1:0]    ram_raddr;

  lpht_key_check u_key_check (
    .word_i     (word_q),
    .too_long_i (too_long_q),
    .info_o     (key)
  );

  lpht_ram #(
    .Width (EntryWidth),
    .Depth (SlotCount)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ins_at),
    .wdata_i ({word_q, payload_q}),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // item capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func_q     <= func_e'(func_i);
      word_q     <= word_i;
      too_long_q <= word_too_long_i;
      payload_q  <= payload_i;
      sel_q      <= slot_select_i;
    end
  end

  assign sel_sat    = (sel_q > LastSlot) ? LastSlot : sel_q;
  assign idx_next   = (idx_q == LastSlot) ? '0 : idx_q + SlotWidth'(1);
  assign cur_status = status_q[idx_q];

  // probe compare: RAM data belongs to idx_q
  always_comb begin
    cur_hit   = 1'b0;
    cur_empty = 1'b0;
    cur_tomb  = 1'b0;
    unique case (cur_status)
      SlotTomb: cur_tomb  = 1'b1;
      SlotUsed: cur_hit   = (rdata[EntryWidth-1:PayloadWidth] == word_q);
      default:  cur_empty = 1'b1;
    endcase
  end

  assign probe_last   = (cnt_q == LastSlot);
  assign probe_stop   = cur_hit || cur_empty || probe_last;
  assign tomb_now_vld = tomb_vld_q || cur_tomb;
  assign tomb_now     = cur_tomb ? idx_q : tomb_q;

  // insert target: matching key, else last tombstone, else the empty slot
  always_comb begin
    ins_do = 1'b1;
    ins_at = idx_q;
    priority if (cur_hit) begin
      ins_at = idx_q;
    end else if (tomb_now_vld) begin
      ins_at = tomb_now;
    end else if (cur_empty) begin
      ins_at = idx_q;
    end else begin
      ins_do = 1'b0;
    end
  end

  assign ram_we = (state_q == StProbe) && probe_stop && (func_q == FuncInsert) && ins_do;

  always_comb begin
    unique case (state_q)
      StCheck: ram_raddr = (func_q == FuncRead) ? sel_sat : key.home;
      StProbe: ram_raddr = idx_next;
      default: ram_raddr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      idx_q            <= '0;
      cnt_q            <= '0;
      tomb_q           <= '0;
      tomb_vld_q       <= 1'b0;
      done_q           <= 1'b0;
      slot_touched_q   <= '0;
      applied_q        <= 1'b0;
      slot_state_q     <= SlotEmpty;
      stored_word_q    <= '0;
      stored_payload_q <= '0;
      rejected_q       <= 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
        status_q[i] <= SlotEmpty;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StCheck;
          end
        end
        StCheck: begin
          slot_touched_q   <= '0;
          applied_q        <= 1'b0;
          slot_state_q     <= SlotEmpty;
          stored_word_q    <= '0;
          stored_payload_q <= '0;
          rejected_q       <= 1'b0;
          cnt_q            <= '0;
          tomb_vld_q       <= 1'b0;
          unique case (func_q)
            FuncRead: begin
              idx_q   <= sel_sat;
              state_q <= StReadOut;
            end
            FuncNop: begin
              done_q  <= 1'b1;
              state_q <= StIdle;
            end
            default: begin
              if (key.ok) begin
                idx_q   <= key.home;
                state_q <= StProbe;
              end else begin
                rejected_q <= 1'b1;
                done_q     <= 1'b1;
                state_q    <= StIdle;
              end
            end
          endcase
        end
        StProbe: begin
          if (cur_tomb) begin
            tomb_q     <= idx_q;
            tomb_vld_q <= 1'b1;
          end
          if (probe_stop) begin
            done_q  <= 1'b1;
            state_q <= StIdle;
            if (func_q == FuncInsert) begin
              if (ins_do) begin
                status_q[ins_at] <= SlotUsed;
                slot_touched_q   <= ins_at;
                applied_q        <= 1'b1;
              end
            end else if (cur_hit) begin
              status_q[idx_q] <= SlotTomb;
              slot_touched_q  <= idx_q;
              applied_q       <= 1'b1;
            end
          end else begin
            idx_q <= idx_next;
            cnt_q <= cnt_q + SlotWidth'(1);
          end
        end
        StReadOut: begin
          done_q         <= 1'b1;
          state_q        <= StIdle;
          slot_touched_q <= idx_q;
          slot_state_q   <= cur_status;
          if (cur_status == SlotUsed) begin
            stored_word_q    <= rdata[EntryWidth-1:PayloadWidth];
            stored_payload_q <= rdata[PayloadWidth-1:0];
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o           = (state_q != StIdle);
  assign done_o           = done_q;
  assign slot_touched_o   = slot_touched_q;
  assign applied_o        = applied_q;
  assign slot_state_o     = slot_state_q;
  assign stored_word_o    = stored_word_q;
  assign stored_payload_o = stored_payload_q;
  assign rejected_o       = rejected_q;

endmodule
